// ===== hw/rtl/ilcr_pkg.sv =====
package ilcr_pkg;

  // Bus event codes from the two-wire slave front end.
  localparam logic [2:0] FN_ADDR = 3'd0;
  localparam logic [2:0] FN_DATA = 3'd1;
  localparam logic [2:0] FN_STOP = 3'd2;
  localparam logic [2:0] FN_NACK = 3'd3;

  // Configuration register indexes.
  localparam logic [7:0] REG_OP_ONE  = 8'd0;
  localparam logic [7:0] REG_OP_ALL  = 8'd1;
  localparam logic [7:0] REG_OP_BANK = 8'd2;

  // Frame lengths, counted in bytes after the command byte.
  localparam logic [2:0] ONE_LEN  = 3'd5;
  localparam logic [2:0] ALL_LEN  = 3'd4;
  localparam logic [2:0] BANK_LEN = 3'd6;
  localparam logic [2:0] BANK_HDR = 3'd2;
  localparam int unsigned FRAME_DEPTH = 6;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_ONE  = 3'd2,
    PH_ALL  = 3'd3,
    PH_BANK = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] op_one;
    logic [7:0] op_all;
    logic [7:0] op_bank;
  } opcodes_t;

  typedef struct packed {
    logic        write_one;
    logic        write_all;
    logic [7:0]  led_index;
    logic [31:0] colour;
    logic        send_strip;
    logic        recover;
  } result_t;

endpackage

// ===== hw/rtl/ilcr_if.sv =====
// Bus event channel.
interface ilcr_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

// LED action channel.
interface ilcr_res_if;
  logic        valid;
  logic        ready;
  logic        write_one;
  logic        write_all;
  logic [7:0]  led_index;
  logic [31:0] colour;
  logic        send_strip;
  logic        recover;

  modport source (output valid, output write_one, output write_all, output led_index,
                  output colour, output send_strip, output recover, input ready);
  modport sink (input valid, input write_one, input write_all, input led_index,
                input colour, input send_strip, input recover, output ready);
endinterface

// Configuration write channel.
interface ilcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ilcr_engine.sv =====
module ilcr_engine
  import ilcr_pkg::*;
#(
  parameter int BANK_SIZE = 8,
  parameter int NUM_LEDS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [2:0] func,
  input  logic [7:0] data_byte,
  input  opcodes_t   opcodes,
  output result_t    result
);

  localparam int POS_W = $clog2(BANK_SIZE + 1);
  localparam int SUM_W = 8 + POS_W + 1;

  phase_t           phase, phase_next;
  logic [2:0]       byte_count, byte_count_next;
  logic [POS_W-1:0] bank_position, bank_position_next;
  logic [7:0]       frame_bytes [FRAME_DEPTH];
  logic             store;
  logic [2:0]       count_inc;
  logic [POS_W-1:0] pos_inc;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] led_sum;

  // Bank base and running LED index, computed without wrap.
  assign count_inc = byte_count + 3'd1;
  assign pos_inc   = bank_position + POS_W'(1);
  assign base      = SUM_W'(frame_bytes[1]) * SUM_W'(BANK_SIZE);
  assign led_sum   = base + SUM_W'(bank_position);

  // Command decode and frame sequencing for one event.
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    bank_position_next = bank_position;
    store              = 1'b0;
    result             = '0;
    unique case (func)
      FN_ADDR: phase_next = PH_CMD;
      FN_DATA: begin
        unique case (phase)
          PH_CMD: begin
            if (data_byte == opcodes.op_one) begin
              byte_count_next = '0;
              phase_next      = PH_ONE;
            end else if (data_byte == opcodes.op_all) begin
              byte_count_next = '0;
              phase_next      = PH_ALL;
            end else if (data_byte == opcodes.op_bank) begin
              byte_count_next    = '0;
              bank_position_next = '0;
              phase_next         = PH_BANK;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_ONE: begin
            store           = 1'b1;
            byte_count_next = count_inc;
            if (count_inc == ONE_LEN) begin
              result.write_one  = 1'b1;
              result.led_index  = frame_bytes[0];
              result.colour     = {data_byte, frame_bytes[3], frame_bytes[2], frame_bytes[1]};
              result.send_strip = 1'b1;
              phase_next        = PH_IDLE;
            end
          end
          PH_ALL: begin
            store           = 1'b1;
            byte_count_next = count_inc;
            if (count_inc == ALL_LEN) begin
              result.write_all  = 1'b1;
              result.colour     = {data_byte, frame_bytes[2], frame_bytes[1], frame_bytes[0]};
              result.send_strip = 1'b1;
              phase_next        = PH_IDLE;
            end
          end
          PH_BANK: begin
            store           = 1'b1;
            byte_count_next = count_inc;
            if (count_inc == BANK_LEN) begin
              result.write_one   = 1'b1;
              result.led_index   = led_sum[7:0];
              result.colour      = {data_byte, frame_bytes[4], frame_bytes[3], frame_bytes[2]};
              bank_position_next = pos_inc;
              byte_count_next    = BANK_HDR;
              if (pos_inc == POS_W'(BANK_SIZE) ||
                  base + SUM_W'(pos_inc) == SUM_W'(NUM_LEDS)) begin
                result.send_strip = (frame_bytes[0] != 8'd0);
                phase_next        = PH_IDLE;
              end
            end
          end
          default: begin
            // Idle, and codes that cannot arise: data bytes are dropped.
          end
        endcase
      end
      FN_STOP: phase_next = PH_IDLE;
      FN_NACK: begin
      end
      default: result.recover = 1'b1;
    endcase
  end

  // Phase and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
    end
  end

  // Bank position and frame buffer hold payload only.
  always_ff @(posedge clk) begin
    if (step) begin
      bank_position <= bank_position_next;
      if (store && byte_count < 3'(FRAME_DEPTH)) begin
        frame_bytes[byte_count] <= data_byte;
      end
    end
  end

endmodule

// ===== hw/rtl/i2c_led_command_receiver.sv =====
// Channel  | Dir | Fields
// ---------+-----+--------------------------------------------------------------
// evt      | in  | func, data_byte
// res      | out | write_one, write_all, led_index, colour, send_strip, recover
// cfg      | in  | index, data (opcode registers 0..2)
//
// One transaction is accepted per cycle while evt.ready is high; each event
// gives one result: an input register, then the decode into the result register.
// The rate is set by the single decode stage, which updates the command state.
// Reset (rst, synchronous) returns to idle and loads the default opcodes 1, 2, 3.
// A stalled result holds both stages; evt.ready drops only when both are full.
module i2c_led_command_receiver
  import ilcr_pkg::*;
#(
  parameter int BANK_SIZE = 8,
  parameter int NUM_LEDS  = 64
) (
  input logic        clk,
  input logic        rst,
  ilcr_evt_if.sink   evt,
  ilcr_res_if.source res,
  ilcr_cfg_if.sink   cfg
);

  opcodes_t   opcodes;
  logic       s1_valid;
  logic [2:0] s1_func;
  logic [7:0] s1_byte;
  logic       out_valid;
  result_t    out_data;
  result_t    result;
  logic       advance;
  logic       step;

  // Pipeline flow control.
  assign advance   = !out_valid || res.ready;
  assign step      = s1_valid && advance;
  assign evt.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  // Opcode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      opcodes.op_one  <= 8'd1;
      opcodes.op_all  <= 8'd2;
      opcodes.op_bank <= 8'd3;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OP_ONE:  opcodes.op_one  <= cfg.data;
        REG_OP_ALL:  opcodes.op_all  <= cfg.data;
        REG_OP_BANK: opcodes.op_bank <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_func <= evt.func;
      s1_byte <= evt.data_byte;
    end
  end

  ilcr_engine #(
    .BANK_SIZE (BANK_SIZE),
    .NUM_LEDS  (NUM_LEDS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .func      (s1_func),
    .data_byte (s1_byte),
    .opcodes   (opcodes),
    .result    (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  assign res.valid      = out_valid;
  assign res.write_one  = out_data.write_one;
  assign res.write_all  = out_data.write_all;
  assign res.led_index  = out_data.led_index;
  assign res.colour     = out_data.colour;
  assign res.send_strip = out_data.send_strip;
  assign res.recover    = out_data.recover;

endmodule

// ===== hw/rtl/ilcr_checker.sv =====
module ilcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        write_one,
  input logic        write_all,
  input logic [7:0]  led_index,
  input logic [31:0] colour,
  input logic        send_strip,
  input logic        recover
);

  // A result never asks for both write kinds at once.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(write_one && write_all))
    else $error("write_one and write_all both set");

  // A bus error result carries no LED action.
  a_recover_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && recover |-> !write_one && !write_all && !send_strip)
    else $error("recover result carries an LED action");

  // Setting every LED always transmits the strip.
  a_all_sends: assert property (@(posedge clk) disable iff (rst)
    res_valid && write_all |-> send_strip)
    else $error("write_all without send_strip");

  // Without a write, index and colour are zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !write_one && !write_all |-> colour == 32'd0 && led_index == 8'd0)
    else $error("nonzero payload without a write");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(colour) && $stable(led_index))
    else $error("stalled result changed");

endmodule

bind i2c_led_command_receiver ilcr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .write_one  (res.write_one),
  .write_all  (res.write_all),
  .led_index  (res.led_index),
  .colour     (res.colour),
  .send_strip (res.send_strip),
  .recover    (res.recover)
);

// ===== tb/sv/i2c_led_command_receiver_tb.sv =====
`timescale 1ns / 100ps

module i2c_led_command_receiver_tb
  import ilcr_pkg::*;
();

  localparam int BANK_SIZE = 8;
  localparam int NUM_LEDS  = 64;

  // Event codes above the stop and nack codes all mean a bus error.
  localparam logic [2:0] FN_BUS_ERROR = 3'd4;
  localparam logic [2:0] FN_LAST      = 3'd7;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_EVENTS = 120;
  localparam int NUM_SETTINGS = 7;
  localparam int REPORT_LIMIT = 10;

  // Tracks the command state, predicts every LED action and checks the results.
  class led_action_scoreboard;
    opcodes_t   opcodes;
    phase_t     phase;
    logic [2:0] held;
    logic [7:0] bank_pos;
    logic [7:0] frame [FRAME_DEPTH];
    result_t    pending_actions [$];
    int         errors;
    int         one_writes;
    int         all_writes;
    int         strip_sends;
    int         recovers;

    function new();
      opcodes  = '{8'd1, 8'd2, 8'd3};
      phase    = PH_IDLE;
      held     = '0;
      bank_pos = '0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    function void set_opcode(logic [7:0] idx, logic [7:0] value);
      case (idx)
        REG_OP_ONE:  opcodes.op_one = value;
        REG_OP_ALL:  opcodes.op_all = value;
        REG_OP_BANK: opcodes.op_bank = value;
        default: ;
      endcase
    endfunction

    // Colour words arrive least significant byte first.
    function logic [31:0] colour_from(int unsigned start);
      return {frame[start + 3], frame[start + 2], frame[start + 1], frame[start]};
    endfunction

    function void hold_byte(logic [7:0] b);
      if (held < FRAME_DEPTH) frame[held] = b;
      held = held + 3'd1;
    endfunction

    function result_t predict_led_action(logic [2:0] fn, logic [7:0] b);
      result_t     act;
      int unsigned base;
      act = '0;
      case (fn)
        FN_ADDR: phase = PH_CMD;
        FN_DATA: begin
          case (phase)
            // The command byte; set one wins over set all, set all over bank.
            PH_CMD: begin
              if (b == opcodes.op_one) begin
                held  = '0;
                phase = PH_ONE;
              end else if (b == opcodes.op_all) begin
                held  = '0;
                phase = PH_ALL;
              end else if (b == opcodes.op_bank) begin
                held     = '0;
                bank_pos = '0;
                phase    = PH_BANK;
              end else begin
                phase = PH_IDLE;
              end
            end
            PH_ONE: begin
              hold_byte(b);
              if (held == ONE_LEN) begin
                act.write_one  = 1'b1;
                act.led_index  = frame[0];
                act.colour     = colour_from(1);
                act.send_strip = 1'b1;
                phase          = PH_IDLE;
              end
            end
            PH_ALL: begin
              hold_byte(b);
              if (held == ALL_LEN) begin
                act.write_all  = 1'b1;
                act.colour     = colour_from(0);
                act.send_strip = 1'b1;
                phase          = PH_IDLE;
              end
            end
            // Each colour of a bank write keeps the flush and bank bytes.
            PH_BANK: begin
              hold_byte(b);
              if (held == BANK_LEN) begin
                base          = frame[1] * BANK_SIZE;
                act.write_one = 1'b1;
                act.led_index = 8'(base + bank_pos);
                act.colour    = colour_from(2);
                bank_pos      = bank_pos + 8'd1;
                held          = BANK_HDR;
                if (bank_pos == BANK_SIZE || base + bank_pos == NUM_LEDS) begin
                  act.send_strip = (frame[0] != 8'd0);
                  phase          = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        FN_STOP: phase = PH_IDLE;
        FN_NACK: ;
        default: act.recover = 1'b1;
      endcase
      return act;
    endfunction

    function void note_event(logic [2:0] fn, logic [7:0] b);
      pending_actions.push_back(predict_led_action(fn, b));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_actions.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result one=%0b all=%0b idx=%02h colour=%08h send=%0b rec=%0b",
                   $time, got.write_one, got.write_all, got.led_index, got.colour,
                   got.send_strip, got.recover);
        return;
      end
      want = pending_actions.pop_front();
      if (got.write_one !== want.write_one || got.write_all !== want.write_all ||
          got.led_index !== want.led_index || got.colour !== want.colour ||
          got.send_strip !== want.send_strip || got.recover !== want.recover) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: mismatch, expected one=%0b all=%0b idx=%02h colour=%08h send=%0b rec=%0b",
                   $time, want.write_one, want.write_all, want.led_index, want.colour,
                   want.send_strip, want.recover);
          $display("%0t:           actual one=%0b all=%0b idx=%02h colour=%08h send=%0b rec=%0b",
                   $time, got.write_one, got.write_all, got.led_index, got.colour,
                   got.send_strip, got.recover);
        end
      end
      if (got.write_one === 1'b1) one_writes++;
      if (got.write_all === 1'b1) all_writes++;
      if (got.send_strip === 1'b1) strip_sends++;
      if (got.recover === 1'b1) recovers++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ilcr_evt_if evt_ch ();
  ilcr_res_if res_ch ();
  ilcr_cfg_if cfg_ch ();

  i2c_led_command_receiver #(
    .BANK_SIZE(BANK_SIZE),
    .NUM_LEDS (NUM_LEDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  led_action_scoreboard board = new();

  bit src_idle_on;
  bit sink_idle_on;
  int sink_stall;
  int items_sent;
  int leftover;

  opcodes_t opcode_plan [NUM_SETTINGS] = '{
    '{8'd1,   8'd2,   8'd3},
    '{8'd0,   8'd255, 8'd128},
    '{8'd255, 8'd0,   8'd255},
    '{8'd9,   8'd9,   8'd9},
    '{8'd4,   8'd4,   8'd0},
    '{8'd17,  8'd200, 8'd200},
    '{8'd1,   8'd2,   8'd3}
  };

  always #5 clk = ~clk;

  // Result monitor and receiver stall bursts.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_result('{res_ch.write_one, res_ch.write_all, res_ch.led_index,
                           res_ch.colour, res_ch.send_strip, res_ch.recover});
    if (sink_stall > 0) begin
      res_ch.ready <= 1'b0;
      sink_stall--;
    end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
      res_ch.ready <= 1'b0;
      sink_stall = $urandom_range(0, 10);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Send one bus event, with an occasional gap before it.
  task automatic send_event(logic [2:0] fn, logic [7:0] b);
    int gap;
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid     <= 1'b1;
    evt_ch.func      <= fn;
    evt_ch.data_byte <= b;
    do @(posedge clk); while (!evt_ch.ready);
    board.note_event(fn, b);
    items_sent++;
  endtask

  // A data byte, now and then preceded by a nack or a bus error.
  task automatic send_data(logic [7:0] b);
    if ($urandom_range(0, 24) == 0)
      send_event($urandom_range(0, 1) ? FN_NACK : 3'($urandom_range(FN_BUS_ERROR, FN_LAST)),
                 8'($urandom));
    send_event(FN_DATA, b);
  endtask

  task automatic send_colour(logic [31:0] c);
    for (int i = 0; i < 4; i++) send_data(c[8 * i +: 8]);
  endtask

  task automatic open_command(logic [7:0] op);
    send_event(FN_ADDR, 8'($urandom));
    send_data(op);
  endtask

  task automatic maybe_stop();
    if ($urandom_range(0, 4) != 0) send_event(FN_STOP, 8'($urandom));
  endtask

  task automatic send_set_one();
    open_command(board.opcodes.op_one);
    send_data(8'($urandom));
    send_colour($urandom);
    maybe_stop();
  endtask

  task automatic send_set_all();
    open_command(board.opcodes.op_all);
    send_colour($urandom);
    maybe_stop();
  endtask

  // Bank write: mostly run to the end of the bank, sometimes cut short.
  task automatic send_bank();
    logic [7:0] flush;
    logic [7:0] bank;
    int         cut;
    flush = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
    bank  = $urandom_range(0, 9) < 4 ? 8'($urandom_range(0, 8)) : 8'($urandom);
    open_command(board.opcodes.op_bank);
    send_data(flush);
    send_data(bank);
    if ($urandom_range(0, 3) != 0) begin
      while (board.phase == PH_BANK) send_colour($urandom);
      maybe_stop();
    end else begin
      cut = $urandom_range(0, BANK_SIZE - 1);
      for (int i = 0; i < cut && board.phase == PH_BANK; i++) send_colour($urandom);
      for (int i = $urandom_range(0, 3); i > 0; i--) send_data(8'($urandom));
      case ($urandom_range(0, 2))
        0: send_event(FN_STOP, 8'($urandom));
        1: send_event(FN_ADDR, 8'($urandom));
        default: send_event(3'($urandom_range(FN_BUS_ERROR, FN_LAST)), 8'($urandom));
      endcase
    end
  endtask

  // Truncated or garbled commands.
  task automatic send_broken();
    logic [7:0] op;
    case ($urandom_range(0, 3))
      0: op = board.opcodes.op_one;
      1: op = board.opcodes.op_all;
      2: op = board.opcodes.op_bank;
      default: op = 8'($urandom);
    endcase
    open_command(op);
    for (int i = $urandom_range(0, 6); i > 0; i--) send_data(8'($urandom));
    send_event($urandom_range(0, 1) ? FN_STOP : FN_ADDR, 8'($urandom));
  endtask

  task automatic send_noise();
    for (int i = $urandom_range(1, 6); i > 0; i--)
      send_event(3'($urandom_range(0, FN_LAST)), 8'($urandom));
  endtask

  task automatic wait_for_results();
    evt_ch.valid <= 1'b0;
    while (board.pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_opcode(idx, value);
  endtask

  task automatic program_opcodes(opcodes_t ops);
    write_reg(REG_OP_ONE, ops.op_one);
    write_reg(REG_OP_ALL, ops.op_all);
    write_reg(REG_OP_BANK, ops.op_bank);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(int quota);
    int stop_at;
    int pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) send_set_one();
      else if (pick < 45) send_set_all();
      else if (pick < 70) send_bank();
      else if (pick < 85) send_broken();
      else send_noise();
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end
  endtask

  // Extremes of every field, each command and the odd events, under reset opcodes.
  task automatic run_directed();
    open_command(board.opcodes.op_one);
    send_event(FN_DATA, 8'hFF);
    send_event(FN_NACK, 8'h00);
    for (int i = 0; i < 4; i++) send_event(FN_DATA, 8'hFF);
    open_command(board.opcodes.op_all);
    for (int i = 0; i < 4; i++) send_event(FN_DATA, 8'h00);
    open_command(board.opcodes.op_bank);
    send_event(FN_DATA, 8'h00);
    send_event(FN_DATA, 8'hFF);
    send_colour(32'hA5C3_0F81);
    send_event(FN_STOP, 8'hFF);
    send_event(FN_DATA, 8'hAA);
    open_command(8'h55);
    send_event(FN_BUS_ERROR, 8'h00);
    send_event(FN_LAST, 8'hFF);
  endtask

  initial begin
    rst              <= 1'b1;
    evt_ch.valid     <= 1'b0;
    evt_ch.func      <= FN_NACK;
    evt_ch.data_byte <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_OP_ONE;
    cfg_ch.data      <= '0;
    items_sent   = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // One random phase per opcode setting; the last one runs without idling.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_for_results();
      if (s > 0) program_opcodes(opcode_plan[s]);
      if (s == NUM_SETTINGS - 1) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      run_random(PHASE_EVENTS);
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    leftover = board.pending_actions.size();

    $display("Covered %0d bus events under %0d opcode settings:", items_sent, NUM_SETTINGS);
    $display("%0d single-LED writes, %0d all-LED writes, %0d strip sends, %0d recover requests.",
             board.one_writes, board.all_writes, board.strip_sends, board.recovers);
    $display("%0d errors, %0d results missing.", board.errors, leftover);
    if (board.errors == 0 && leftover == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
